// ----- rtl/core/bounded_multiset_table_assert.svh -----
// Assertion macros for the bounded multiset table checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BOUNDED_MULTISET_TABLE_ASSERT_SVH
`define BOUNDED_MULTISET_TABLE_ASSERT_SVH

// same-cycle implication
`define BMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bmt_pkg.sv -----
// Shared types and constants for the bounded multiset table.
// No dependencies.
`timescale 1ns / 1ps

package bmt_pkg;

	localparam int CAP_W = 5;
	localparam int MCNT_W = 5;
	localparam int FIDX_W = 4;
	localparam int ECNT_W = 5;
	localparam logic [CAP_W-1:0] CAPACITY_AT_RESET = 5'd10;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_CLEAR  = 2'd2,
		FN_QUERY  = 2'd3
	} func_t;

	typedef struct packed {
		logic clr;
		logic en;
	} match_ctl_t;

	typedef struct packed {
		logic [ECNT_W-1:0] entry_count;
		logic [FIDX_W-1:0] first_index;
		logic              found;
		logic [MCNT_W-1:0] match_count;
		logic              ok;
	} result_t;

endpackage

// ----- rtl/core/bmt_match.sv -----
// Shared compare unit: one stored word against the key per cycle, tracks
// presence, first hit index and hit count. Depends on bmt_pkg.
`timescale 1ns / 1ps

module bmt_match #(
	parameter int KEY_BITS = 32,
	parameter int IW = 4,
	parameter int CW = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmt_pkg::match_ctl_t  ctl,
	input  logic [IW-1:0]        idx,
	input  logic [KEY_BITS-1:0]  key,
	input  logic [KEY_BITS-1:0]  slot,
	output logic                 present,
	output logic [IW-1:0]        first,
	output logic [CW-1:0]        hit_cnt
);

	logic          present_q;
	logic [IW-1:0] first_q;
	logic [CW-1:0] matches_q;
	logic          hit;

	assign hit = ctl.en && (slot == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			first_q   <= '0;
			matches_q <= '0;
		end else if (ctl.clr) begin
			present_q <= 1'b0;
			first_q   <= '0;
			matches_q <= '0;
		end else if (hit) begin
			if (!present_q) begin
				first_q <= idx;
			end
			present_q <= 1'b1;
			matches_q <= matches_q + CW'(1);
		end
	end

	assign present = present_q;
	assign first   = first_q;
	assign hit_cnt = matches_q;

endmodule

// ----- rtl/core/bmt_seq.sv -----
// Command sequencer with the slot memory and entry count.
// Depends on bmt_pkg and bmt_match.
`timescale 1ns / 1ps

module bmt_seq #(
	parameter int DEPTH = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  bmt_pkg::func_t               func,
	input  logic [KEY_BITS-1:0]          key,
	input  logic [bmt_pkg::CAP_W-1:0]    cap,
	output logic                         idle,
	output logic                         res_valid,
	input  logic                         res_ready,
	output bmt_pkg::result_t             res
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_OP      = 6'b000100,
		ST_MOVE_RD = 6'b001000,
		ST_MOVE_WR = 6'b010000,
		ST_FINISH  = 6'b100000
	} state_t;

	state_t               state_q;
	bmt_pkg::func_t       func_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        ptr_q;
	logic                 ok_q;
	logic                 issue_s1;
	logic [IW-1:0]        idx_s1;
	logic [KEY_BITS-1:0]  rd_data_s1;

	logic [KEY_BITS-1:0]  mem [DEPTH];

	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [KEY_BITS-1:0]  wr_data;
	logic                 scan_more;
	logic                 add_room;
	logic [31:0]          lim;
	logic [IW-1:0]        last_idx;

	bmt_pkg::match_ctl_t  mctl;
	logic                 present;
	logic [IW-1:0]        first;
	logic [CW-1:0]        hit_cnt;

	assign scan_more = ptr_q < count_q;
	assign lim       = (32'(cap) > DEPTH) ? 32'(DEPTH) : 32'(cap);
	assign add_room  = 32'(count_q) < lim;
	assign last_idx  = IW'(count_q - CW'(1));

	assign mctl.clr = start;
	assign mctl.en  = issue_s1;

	bmt_match #(
		.KEY_BITS(KEY_BITS),
		.IW(IW),
		.CW(CW)
	) u_match (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mctl),
		.idx(idx_s1),
		.key(key_q),
		.slot(rd_data_s1),
		.present(present),
		.first(first),
		.hit_cnt(hit_cnt)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = IW'(ptr_q);
		wr_en   = 1'b0;
		wr_addr = IW'(count_q);
		wr_data = key_q;
		unique case (state_q)
			ST_SCAN: begin
				rd_en = scan_more;
			end
			ST_OP: begin
				wr_en = (func_q == bmt_pkg::FN_ADD) && add_room;
			end
			ST_MOVE_RD: begin
				rd_en   = 1'b1;
				rd_addr = last_idx;
			end
			ST_MOVE_WR: begin
				wr_en   = 1'b1;
				wr_addr = first;
				wr_data = rd_data_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			func_q <= func;
			key_q  <= key;
		end
		idx_s1 <= IW'(ptr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			ok_q     <= 1'b0;
			issue_s1 <= 1'b0;
		end else begin
			issue_s1 <= (state_q == ST_SCAN) && scan_more;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						ptr_q <= '0;
						if (func == bmt_pkg::FN_CLEAR) begin
							count_q <= '0;
							ok_q    <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_more) begin
						ptr_q <= ptr_q + CW'(1);
					end else begin
						state_q <= ST_OP;
					end
				end
				ST_OP: begin
					state_q <= ST_FINISH;
					unique case (func_q)
						bmt_pkg::FN_ADD: begin
							ok_q <= add_room;
							if (add_room) begin
								count_q <= count_q + CW'(1);
							end
						end
						bmt_pkg::FN_REMOVE: begin
							ok_q <= present;
							if (present) begin
								state_q <= ST_MOVE_RD;
							end
						end
						bmt_pkg::FN_CLEAR: begin
							ok_q <= 1'b1;
						end
						bmt_pkg::FN_QUERY: begin
							ok_q <= present;
						end
						default: begin
							ok_q <= 1'b0;
						end
					endcase
				end
				ST_MOVE_RD: begin
					state_q <= ST_MOVE_WR;
				end
				ST_MOVE_WR: begin
					count_q <= count_q - CW'(1);
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FINISH);

	assign res.ok          = ok_q;
	assign res.match_count = bmt_pkg::MCNT_W'(hit_cnt);
	assign res.found       = present;
	assign res.first_index = bmt_pkg::FIDX_W'(first);
	assign res.entry_count = bmt_pkg::ECNT_W'(count_q);

endmodule

// ----- rtl/core/bounded_multiset_table.sv -----
// Top level of the bounded multiset table: stream ports, capacity register,
// output register. Depends on bmt_pkg and bmt_seq.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser = func, s_tdata = entry_value
// m_*       out  m_tvalid/m_tready  m_tdata = result fields
// cfg_*     in   cfg_we             cfg_wdata = capacity_limit
//
// Add, remove and query first scan all stored entries, and a remove that
// finds the word copies the last entry over its first hit; clear skips the scan.
// The scan reads one slot per cycle via one read port and one shared comparator.
// A finished result sits in the output register; the next transaction is
// taken while it waits, and the sequencer holds only if a second result is due.
// Reset empties the table at once and sets the capacity to 10.
`timescale 1ns / 1ps

module bounded_multiset_table #(
	parameter int DEPTH = 16,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] entry_value
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] ok, [5:1] match_count, [6] found,
	                               // [10:7] first_index, [15:11] entry_count
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata  // [4:0] capacity_limit
);

	logic [bmt_pkg::CAP_W-1:0] cap_q;
	logic                      m_tvalid_q;
	bmt_pkg::result_t          m_res_q;
	logic                      idle;
	logic                      start;
	logic                      res_valid;
	logic                      res_ready;
	bmt_pkg::result_t          res;

	assign s_tready  = idle;
	assign start     = s_tvalid && idle;
	assign res_ready = !m_tvalid_q || m_tready;

	bmt_seq #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(bmt_pkg::func_t'(s_tuser)),
		.key(KEY_BITS'(s_tdata)),
		.cap(cap_q),
		.idle(idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bmt_pkg::CAPACITY_AT_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_res_q;

endmodule

// ----- rtl/core/bmt_chk.sv -----
// Port-level checker for the bounded multiset table, bound to the top level.
// Depends on bounded_multiset_table_assert.svh.
`timescale 1ns / 1ps
`include "bounded_multiset_table_assert.svh"

module bmt_chk #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`BMT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`BMT_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")
	`BMT_ASSERT_NOW(a_absent_zero, m_tvalid && !m_tdata[6], (m_tdata[5:1] == 5'd0) && (m_tdata[10:7] == 4'd0), "absent word with nonzero count or index")
	`BMT_ASSERT_NOW(a_count_bound, m_tvalid, (32'(m_tdata[15:11]) <= DEPTH) && (!m_tdata[6] || (m_tdata[5:1] != 5'd0)), "entry count above depth or found without match")

endmodule

bind bounded_multiset_table bmt_chk #(
	.DEPTH(DEPTH)
) u_bmt_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
